### hw/rtl/bisom_pkg.sv
package bisom_pkg;
  localparam int MAX_SIDE   = 256;
  localparam int MAX_SHIFTS = 64;
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int IDX_W      = $clog2(MAX_SIDE);
  localparam int ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int SHL_W      = $clog2(MAX_SHIFTS + 1);
  localparam int SH_W       = 6;
  localparam int CNT_W      = $clog2(2 * DEPTH + 1);
  localparam int RATIO_W    = 16;
  localparam int QDEPTH     = 2;

  localparam logic [0:0] REG_SIDE  = 1'b0;
  localparam logic [0:0] REG_LIMIT = 1'b1;

  typedef struct packed {
    logic              a;
    logic              b;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } bisom_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_SCAN, ST_DIV_F, ST_DIV_R, ST_DONE
  } bisom_state_t;
endpackage

### hw/rtl/bisom_ram.sv
module bisom_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/bisom_front.sv
module bisom_front import bisom_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_start,
  input  logic       in_pixel_a,
  input  logic       in_pixel_b,
  input  logic       in_last_pixel,
  input  logic       q_full,
  input  logic       back_busy,
  output logic       accept,
  output bisom_cmd_t cmd
);
  // load address, wraps over the store; last pair returns it to zero
  logic [ADDR_W-1:0] pos_r, pos_nxt;

  assign accept = in_start && !q_full && !back_busy;

  always_comb begin
    cmd.a    = in_pixel_a;
    cmd.b    = in_pixel_b;
    cmd.last = in_last_pixel;
    cmd.addr = pos_r;
    pos_nxt  = pos_r;
    if (accept) begin
      pos_nxt = in_last_pixel ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end
endmodule

### hw/rtl/bisom_queue.sv
module bisom_queue import bisom_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bisom_cmd_t din,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output bisom_cmd_t dout
);
  localparam int PW = $clog2(QDEPTH);
  bisom_cmd_t      slot_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

### hw/rtl/bisom_back.sv
module bisom_back import bisom_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [8:0]          side_cfg,
  input  logic [6:0]          limit_cfg,
  input  logic                q_empty,
  input  bisom_cmd_t          q_cmd,
  output logic                q_pop,
  output logic                busy,
  output logic                res_valid,
  output logic [RATIO_W-1:0]  res_ratio,
  output logic [SH_W-1:0]     res_row,
  output logic [SH_W-1:0]     res_col,
  output logic                res_dir
);
  bisom_state_t st_r, st_nxt;

  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [SHL_W-1:0]  lim_r, lim_nxt;
  logic [SH_W:0]     r_r, r_nxt, c_r, c_nxt;
  logic [IDX_W:0]    k_r, k_nxt, l_r, l_nxt;
  logic              rd_v_r, rd_v_nxt;        // read data valid next cycle
  logic              rd_last_r, rd_last_nxt;  // last read of the region
  logic [CNT_W-1:0]  fwd_r, fwd_nxt, rev_r, rev_nxt, den_r, den_nxt;
  logic [CNT_W+16:0] rem_r, rem_nxt;
  logic [CNT_W+16:0] quo_r, quo_nxt;
  logic [5:0]        dstep_r, dstep_nxt;
  logic [RATIO_W-1:0] best_r, best_nxt;
  logic [SH_W-1:0]   br_r, br_nxt, bc_r, bc_nxt;
  logic              bd_r, bd_nxt;

  // memory ports
  logic              we;
  logic [ADDR_W-1:0] ra0, ra1;
  logic              a0, b0, a1, b1, a0u, b0u, a1u, b1u;

  logic [2*SIDE_W+1:0] addr0_w, addr1_w;
  logic [CNT_W+16:0]   trial;
  logic [RATIO_W-1:0]  ratio_sat;

  assign we = q_pop;

  bisom_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ra0 (.clk, .we, .waddr(q_cmd.addr),
    .wdata(q_cmd.a), .raddr(ra0), .rdata(a0u));
  bisom_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_rb0 (.clk, .we, .waddr(q_cmd.addr),
    .wdata(q_cmd.b), .raddr(ra0), .rdata(b0u));
  bisom_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ra1 (.clk, .we, .waddr(q_cmd.addr),
    .wdata(q_cmd.a), .raddr(ra1), .rdata(a1u));
  bisom_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_rb1 (.clk, .we, .waddr(q_cmd.addr),
    .wdata(q_cmd.b), .raddr(ra1), .rdata(b1u));

  assign a0 = a0u; assign b0 = b0u; assign a1 = a1u; assign b1 = b1u;

  // row*side + col; one narrow multiply per port
  assign addr0_w = (2*SIDE_W+2)'(k_r) * (2*SIDE_W+2)'(side_r) + (2*SIDE_W+2)'(l_r);
  assign addr1_w = (2*SIDE_W+2)'(k_r + r_r) * (2*SIDE_W+2)'(side_r)
                 + (2*SIDE_W+2)'(l_r + c_r);
  assign ra0 = addr0_w[ADDR_W-1:0];
  assign ra1 = addr1_w[ADDR_W-1:0];

  assign busy  = (st_r != ST_IDLE);
  assign q_pop = (st_r == ST_IDLE) && !q_empty;

  assign trial     = {rem_r[CNT_W+15:0], quo_r[CNT_W+16]} ;
  assign ratio_sat = (|quo_r[CNT_W+16:RATIO_W]) ? '1 : quo_r[RATIO_W-1:0];

  always_comb begin
    st_nxt = st_r;
    side_nxt = side_r; lim_nxt = lim_r;
    r_nxt = r_r; c_nxt = c_r; k_nxt = k_r; l_nxt = l_r;
    rd_v_nxt = 1'b0; rd_last_nxt = 1'b0;
    fwd_nxt = fwd_r; rev_nxt = rev_r; den_nxt = den_r;
    rem_nxt = rem_r; quo_nxt = quo_r; dstep_nxt = dstep_r;
    best_nxt = best_r; br_nxt = br_r; bc_nxt = bc_r; bd_nxt = bd_r;
    res_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.last) begin
          side_nxt = (side_cfg == '0) ? SIDE_W'(1)
                   : (side_cfg > 9'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(side_cfg);
          lim_nxt  = (limit_cfg > 7'(MAX_SHIFTS)) ? SHL_W'(MAX_SHIFTS) : SHL_W'(limit_cfg);
          r_nxt = '0; c_nxt = '0;
          best_nxt = '0; br_nxt = '0; bc_nxt = '0; bd_nxt = 1'b0;
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // pick next valid shift or finish
        if ((SHL_W+1)'(r_r) >= (SHL_W+1)'(lim_r)) begin
          st_nxt = ST_DONE;
        end else if ((SHL_W+1)'(c_r) >= (SHL_W+1)'(lim_r)) begin
          c_nxt = '0; r_nxt = r_r + 1'b1;
        end else if ((SIDE_W+1)'(r_r) >= (SIDE_W+1)'(side_r)
                  || (SIDE_W+1)'(c_r) >= (SIDE_W+1)'(side_r)) begin
          c_nxt = c_r + 1'b1;
        end else begin
          k_nxt = '0; l_nxt = '0;
          fwd_nxt = '0; rev_nxt = '0; den_nxt = '0;
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_v_r) begin
          den_nxt = den_r + CNT_W'(a0) + CNT_W'(b0);
          fwd_nxt = fwd_r + CNT_W'(a0 & b1);
          rev_nxt = rev_r + CNT_W'(b0 & a1);
        end
        if (rd_last_r) begin
          quo_nxt = (CNT_W+17)'(fwd_nxt) << 16;
          rem_nxt = '0; dstep_nxt = '0;
          st_nxt = (den_nxt == '0) ? ST_SHIFT : ST_DIV_F;
          if (den_nxt == '0) c_nxt = c_r + 1'b1;
        end else if (!rd_v_r || k_r != '1) begin
          // issue read at (k,l)
          if ((IDX_W+1)'(k_r) < (IDX_W+1)'(side_r - (SIDE_W)'(r_r))) begin
            rd_v_nxt = 1'b1;
            if ((IDX_W+1)'(l_r) + 1'b1 >= (IDX_W+1)'(side_r - SIDE_W'(c_r))) begin
              l_nxt = '0; k_nxt = k_r + 1'b1;
              rd_last_nxt = ((IDX_W+1)'(k_r) + 1'b1
                           >= (IDX_W+1)'(side_r - SIDE_W'(r_r)));
            end else begin
              l_nxt = l_r + 1'b1;
            end
          end
        end
      end
      ST_DIV_F, ST_DIV_R: begin
        // restoring divide, one quotient bit a cycle
        if (trial >= (CNT_W+17)'(den_r)) begin
          rem_nxt = trial - (CNT_W+17)'(den_r);
          quo_nxt = {quo_r[CNT_W+15:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[CNT_W+15:0], 1'b0};
        end
        dstep_nxt = dstep_r + 1'b1;
        if (dstep_r == 6'(CNT_W + 17)) begin
          quo_nxt = quo_r;
          rem_nxt = rem_r;
          if (st_r == ST_DIV_F) begin
            if (ratio_sat > best_r) begin
              best_nxt = ratio_sat; br_nxt = r_r[SH_W-1:0];
              bc_nxt = c_r[SH_W-1:0]; bd_nxt = 1'b0;
            end
            quo_nxt = (CNT_W+17)'(rev_r) << 16;
            rem_nxt = '0; dstep_nxt = '0;
            st_nxt = ST_DIV_R;
          end else begin
            if (ratio_sat > best_r) begin
              best_nxt = ratio_sat; br_nxt = r_r[SH_W-1:0];
              bc_nxt = c_r[SH_W-1:0]; bd_nxt = 1'b1;
            end
            c_nxt = c_r + 1'b1;
            st_nxt = ST_SHIFT;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign res_ratio = best_r;
  assign res_row   = br_r;
  assign res_col   = bc_r;
  assign res_dir   = bd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; rd_v_r <= 1'b0; rd_last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rd_v_r <= rd_v_nxt; rd_last_r <= rd_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt; lim_r <= lim_nxt;
    r_r <= r_nxt; c_r <= c_nxt; k_r <= k_nxt; l_r <= l_nxt;
    fwd_r <= fwd_nxt; rev_r <= rev_nxt; den_r <= den_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; dstep_r <= dstep_nxt;
    best_r <= best_nxt; br_r <= br_nxt; bc_r <= bc_nxt; bd_r <= bd_nxt;
  end
endmodule

### hw/rtl/binary_image_shift_overlap_match.sv
// channel | ports                                   | handshake
// input   | in_pixel_a, in_pixel_b, in_last_pixel   | start high, busy low
// result  | out_best_ratio/_row_shift/_col_shift/_direction | out_valid, one cycle
// config  | cfg_index, cfg_data                     | cfg_valid and cfg_ready
// Ordinary pairs: one a cycle while busy is low, written to the stores through
// a two-entry queue. Last pair: each shift in range has a set-up step, an overlap
// scan and, if a pixel is set, two divides; a skipped shift has the set-up only.
// busy is high while the queue is full and from the last pair until the result.
// Reset: synchronous, active low; registers to 200 and 50, load address 0.
// The receiver cannot stall; out_valid is a single-cycle strobe.
module binary_image_shift_overlap_match import bisom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_pixel_a,
  input  logic        in_pixel_b,
  input  logic        in_last_pixel,
  output logic        out_valid,
  output logic [15:0] out_best_ratio,
  output logic [5:0]  out_best_row_shift,
  output logic [5:0]  out_best_col_shift,
  output logic        out_best_direction,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  logic [8:0] side_r;
  logic [6:0] limit_r;
  logic       accept, q_full, q_empty, q_pop, back_busy;
  logic       match_busy;
  bisom_cmd_t cmd, q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= 9'd200;
      limit_r <= 7'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIDE:  side_r  <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // front blocks while a match runs, a last pair waits or the queue fills
  assign busy = q_full || back_busy;

  bisom_front u_front (.clk, .rst_n, .in_start(start), .in_pixel_a, .in_pixel_b,
    .in_last_pixel, .q_full, .back_busy, .accept, .cmd);

  bisom_queue u_queue (.clk, .rst_n, .push(accept), .din(cmd), .pop(q_pop),
    .full(q_full), .empty(q_empty), .dout(q_cmd));

  // back part busy while a last pair waits or matching runs; a last pair
  // behind an ordinary one leaves the queue full
  assign back_busy = match_busy || (!q_empty && q_cmd.last);

  bisom_back u_back (.clk, .rst_n, .side_cfg(side_r), .limit_cfg(limit_r),
    .q_empty, .q_cmd, .q_pop, .busy(match_busy), .res_valid(out_valid),
    .res_ratio(out_best_ratio), .res_row(out_best_row_shift),
    .res_col(out_best_col_shift), .res_dir(out_best_direction));
endmodule

### hw/rtl/bisom_checker.sv
module bisom_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_best_direction,
  input logic [15:0] out_best_ratio
);
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_best_ratio == 16'd0 |-> !out_best_direction)
    else $error("direction set with zero ratio");
endmodule

bind binary_image_shift_overlap_match bisom_checker u_chk (.clk, .rst_n,
  .busy, .out_valid, .out_best_direction, .out_best_ratio);

### sim/tb_top.sv
module tb_top;
  import bisom_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // DUT connections
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_pixel_a;
  logic        in_pixel_b;
  logic        in_last_pixel;
  logic        out_valid;
  logic [15:0] out_best_ratio;
  logic [5:0]  out_best_row_shift;
  logic [5:0]  out_best_col_shift;
  logic        out_best_direction;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [8:0]  cfg_data;

  // one expected match result
  typedef struct packed {
    logic [15:0] ratio;
    logic [5:0]  row_shift;
    logic [5:0]  col_shift;
    logic        direction;
  } match_t;

  // local copy of the block's state
  bit          plane_a [DEPTH];
  bit          plane_b [DEPTH];
  int unsigned load_addr;
  int unsigned loaded_hi;  // addresses below this have been written since reset
  int unsigned side_reg;
  int unsigned limit_reg;

  match_t      pending_matches[$];
  int          mismatches;
  bit          calm;       // no idle gaps while set
  int          pairs_sent;

  binary_image_shift_overlap_match dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous overall limit: several times the worst run of small images
  // under the widest shift limits
  initial begin
    #(12 * 20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // best shift search over the stored planes, same scan order as the block
  function automatic match_t best_overlap();
    match_t      best;
    int unsigned s, lim, den, fwd, rev, q;
    bit          a0, b0, a1, b1;
    best = '0;
    s    = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
    lim  = (limit_reg > MAX_SHIFTS) ? MAX_SHIFTS : limit_reg;
    for (int r = 0; r < lim; r++) begin
      for (int c = 0; c < lim; c++) begin
        if (r >= s || c >= s) continue;
        den = 0; fwd = 0; rev = 0;
        for (int k = 0; k < s - r; k++) begin
          for (int l = 0; l < s - c; l++) begin
            a0 = plane_a[k * s + l];
            b0 = plane_b[k * s + l];
            a1 = plane_a[(k + r) * s + l + c];
            b1 = plane_b[(k + r) * s + l + c];
            den += a0 + b0;
            fwd += a0 & b1;
            rev += b0 & a1;
          end
        end
        if (den == 0) continue;
        q = longint'(fwd) * 65536 / den;
        if (q > 65535) q = 65535;
        if (q > best.ratio) begin
          best.ratio = q; best.row_shift = r; best.col_shift = c; best.direction = 1'b0;
        end
        q = longint'(rev) * 65536 / den;
        if (q > 65535) q = 65535;
        if (q > best.ratio) begin
          best.ratio = q; best.row_shift = r; best.col_shift = c; best.direction = 1'b1;
        end
      end
    end
    return best;
  endfunction

  // update the local state for one accepted pair
  task automatic predict_pair(input bit a, input bit b, input bit last);
    plane_a[load_addr] = a;
    plane_b[load_addr] = b;
    if (load_addr + 1 > loaded_hi) loaded_hi = load_addr + 1;
    load_addr = (load_addr + 1) % DEPTH;
    if (last) begin
      pending_matches.push_back(best_overlap());
      load_addr = 0;
    end
  endtask

  // send one pixel pair; start is left high so back-to-back pairs flow
  task automatic send_pair(input bit a, input bit b, input bit last);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start         <= 1'b1;
    in_pixel_a    <= a;
    in_pixel_b    <= b;
    in_last_pixel <= last;
    do @(posedge clk); while (busy);
    predict_pair(a, b, last);
    pairs_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // wait for every expected result, then let any queued pairs settle
  task automatic drain();
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[8:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SIDE) side_reg = val[8:0];
    else limit_reg = val[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned eff_side();
    return (side_reg == 0) ? 1 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
  endfunction

  // full image of the current side; density in percent of set pixels
  task automatic send_image(input int dens_a, input int dens_b);
    int unsigned n;
    n = eff_side() * eff_side();
    for (int unsigned i = 0; i < n; i++)
      send_pair($urandom_range(99) < dens_a, $urandom_range(99) < dens_b, i == n - 1);
    stop_input();
  endtask

  // result checker: a strobe with nothing expected is a failure
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid) begin
      if (pending_matches.size() == 0) begin
        $display("%0t unexpected result transfer", $time);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (out_best_ratio !== want.ratio)
          report("best_ratio", out_best_ratio, want.ratio);
        if (out_best_row_shift !== want.row_shift)
          report("best_row_shift", out_best_row_shift, want.row_shift);
        if (out_best_col_shift !== want.col_shift)
          report("best_col_shift", out_best_col_shift, want.col_shift);
        if (out_best_direction !== want.direction)
          report("best_direction", out_best_direction, want.direction);
      end
    end
  end

  // directed: empty, full, one-sided and identical images, odd sizes and limits
  task automatic test_directed();
    write_reg(REG_SIDE, 4);
    write_reg(REG_LIMIT, 4);
    send_image(0, 0);      // nothing set: all-zero result
    send_image(100, 100);  // everything set
    send_image(100, 0);    // only first image: no ratio above zero
    send_image(0, 100);
    drain();
    // identical images
    for (int i = 0; i < 16; i++) begin
      bit p;
      p = $urandom_range(1);
      send_pair(p, p, i == 15);
    end
    stop_input();
    write_reg(REG_SIDE, 0);   // side zero behaves as one
    write_reg(REG_LIMIT, 1);
    send_image(100, 100);
    write_reg(REG_SIDE, 1);
    send_image(100, 0);
    write_reg(REG_LIMIT, 0);  // no shift tried
    write_reg(REG_SIDE, 3);
    send_image(100, 100);
    write_reg(REG_LIMIT, 127); // saturates; shifts beyond the side are skipped
    send_image(60, 60);
    write_reg(REG_LIMIT, 64);
    send_image(50, 50);
    // early last pair, allowed since the whole 3x3 region is already written
    send_pair(1, 1, 0);
    send_pair(0, 1, 1);
    stop_input();
  endtask

  // largest side, at the limit and saturating from above; with no shift tried
  // nothing is read, so a single pair stands for a whole image
  task automatic test_largest_side();
    write_reg(REG_LIMIT, 0);
    write_reg(REG_SIDE, 256);
    send_pair(1, 0, 1);
    stop_input();
    write_reg(REG_SIDE, 511);
    send_pair(0, 1, 1);
    stop_input();
  endtask

  // sender holds off until every result has arrived before each image;
  // the images themselves go back to back
  task automatic test_hold_off();
    write_reg(REG_SIDE, 5);
    write_reg(REG_LIMIT, 5);
    calm = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_image($urandom_range(100), $urandom_range(100));
      while (pending_matches.size() != 0) @(posedge clk);
    end
    calm = 1'b0;
  endtask

  // random images, mostly well-formed, some with stray or truncated sequences
  task automatic test_random();
    int unsigned target, n, pick;
    int          da, db;
    target = pairs_sent + 450;
    while (pairs_sent < target) begin
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(19);
        write_reg(REG_SIDE, pick == 0 ? 0 : $urandom_range(1, 8));
        write_reg(REG_LIMIT, pick == 1 ? 127 : (pick == 2 ? 64 : $urandom_range(0, 9)));
      end
      calm = ($urandom_range(9) == 0);
      da = $urandom_range(4) * 25;
      db = $urandom_range(4) * 25;
      n  = eff_side() * eff_side();
      pick = $urandom_range(9);
      if (pick == 0) begin
        // stray pairs ahead of the image shift its position in the store
        repeat ($urandom_range(1, 5)) send_pair($urandom_range(1), $urandom_range(1), 0);
        send_image(da, db);
      end else if (pick == 1 && loaded_hi >= n && n > 1) begin
        // truncated image: region was fully written earlier
        n = $urandom_range(1, n - 1);
        for (int unsigned i = 0; i < n; i++)
          send_pair($urandom_range(99) < da, $urandom_range(99) < db, i == n - 1);
        stop_input();
      end else begin
        send_image(da, db);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_pixel_a    = 1'b0;
    in_pixel_b    = 1'b0;
    in_last_pixel = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_SIDE;
    cfg_data      = '0;
    mismatches    = 0;
    calm          = 1'b0;
    pairs_sent    = 0;
    load_addr     = 0;
    loaded_hi     = 0;
    side_reg      = 200;
    limit_reg     = 50;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_hold_off();
    test_random();
    test_largest_side();

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bisom_pkg.sv
hw/rtl/bisom_ram.sv
hw/rtl/bisom_front.sv
hw/rtl/bisom_queue.sv
hw/rtl/bisom_back.sv
hw/rtl/binary_image_shift_overlap_match.sv
hw/rtl/bisom_checker.sv
sim/tb_top.sv
